// File: rtl/core/circle_fit_worst_residual_search_unit_defines.svh
// ----------------------------------------------------------------------------
// circle_fit_worst_residual_search_unit_defines.svh
// assertion macros used by the checker of the worst-residual search
// ----------------------------------------------------------------------------
`ifndef CIRCLE_FIT_WORST_RESIDUAL_SEARCH_UNIT_DEFINES_SVH
`define CIRCLE_FIT_WORST_RESIDUAL_SEARCH_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CFWRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CFWRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cfwrs_pkg.sv
// ----------------------------------------------------------------------------
// cfwrs_pkg
// widths, register indexes and shared constants of the worst-residual search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfwrs_pkg;

  // field widths
  localparam int unsigned COORD_W  = 20;
  localparam int unsigned RADIUS_W = 19;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned FACE_W   = 7;
  localparam int unsigned PANEL_W  = 2;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned CHI2_W   = 48;

  // result position fields carry one extra sign bit
  localparam int unsigned WFACE_W  = FACE_W + 1;
  localparam int unsigned WPANEL_W = PANEL_W + 1;
  localparam int unsigned WINDEX_W = INDEX_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = CHI2_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_RADIUS     = 3'd2,
    REG_CHI2_START = 3'd3,
    REG_SEED_FACE  = 3'd4,
    REG_SEED_PANEL = 3'd5,
    REG_SEED_HIT   = 3'd6
  } cfg_reg_e;

  // arithmetic unit sizes
  localparam int unsigned MAG_W      = COORD_W;       // |dx|, |dy|
  localparam int unsigned ROOT_W     = COORD_W + 1;   // floor sqrt of dx^2+dy^2
  localparam int unsigned RAD_W      = 2 * ROOT_W;    // radicand, padded to even
  localparam int unsigned SQRT_CNT_W = $clog2(ROOT_W);
  localparam int unsigned MUL_W      = ROOT_W;        // shared multiplier operand
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned ACC_W      = 2 * MAG_W;     // holds dx^2 or sq_lo*w
  localparam int unsigned PART_W     = MUL_W + WEIGHT_W; // one half of sq times w
  localparam int unsigned SUM_W      = PART_W + MUL_W + 1;

endpackage

// File: rtl/core/cfwrs_channels.sv
// ----------------------------------------------------------------------------
// cfwrs_channels
// valid/ready channels: hit input, result output and configuration write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfwrs_hit_if;
  import cfwrs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  hit_x;
  logic signed [COORD_W-1:0]  hit_y;
  logic [WEIGHT_W-1:0]        hit_weight;
  logic                       used;
  logic [FACE_W-1:0]          face;
  logic [PANEL_W-1:0]         panel;
  logic [INDEX_W-1:0]         hit_index;
  logic                       last;

  modport source (output valid, hit_x, hit_y, hit_weight, used, face, panel,
                  hit_index, last, input ready);
  modport sink   (input valid, hit_x, hit_y, hit_weight, used, face, panel,
                  hit_index, last, output ready);
endinterface

interface cfwrs_res_if;
  import cfwrs_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [CHI2_W-1:0]           worst_chi2;
  logic signed [WFACE_W-1:0]   worst_face;
  logic signed [WPANEL_W-1:0]  worst_panel;
  logic signed [WINDEX_W-1:0]  worst_index;

  modport source (output valid, found, worst_chi2, worst_face, worst_panel,
                  worst_index, input ready);
  modport sink   (input valid, found, worst_chi2, worst_face, worst_panel,
                  worst_index, output ready);
endinterface

interface cfwrs_cfg_if;
  import cfwrs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/cfwrs_isqrt.sv
// ----------------------------------------------------------------------------
// cfwrs_isqrt
// iterative integer square root, one result bit per cycle, rounds down
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfwrs_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cfwrs_pkg::RAD_W-1:0] radicand_i,
  output logic [cfwrs_pkg::ROOT_W-1:0] root_o,
  output logic                        done_o
);
  import cfwrs_pkg::*;

  localparam logic [SQRT_CNT_W-1:0] LastStep = SQRT_CNT_W'(ROOT_W - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_W+2:0]     rem_q, rem_sh, trial, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic                  fits;

  // bring down the next two radicand bits and try a one
  always_comb begin
    rem_sh = {rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = rem_sh >= trial;
    rem_d  = fits ? rem_sh - trial : rem_sh;
    root_d = {root_q[ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/cfwrs_mul.sv
// ----------------------------------------------------------------------------
// cfwrs_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfwrs_mul (
  input  logic                          clk_i,
  input  logic [cfwrs_pkg::MUL_W-1:0]   a_i,
  input  logic [cfwrs_pkg::MUL_W-1:0]   b_i,
  output logic [cfwrs_pkg::PROD_W-1:0]  p_o
);
  import cfwrs_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/circle_fit_worst_residual_search_unit.sv
// ----------------------------------------------------------------------------
// circle_fit_worst_residual_search_unit
// streams hits of one scan, finds the hit with the largest weighted residual
// ----------------------------------------------------------------------------
//
// channel  dir  transaction
// -------  ---  --------------------------------------------------------------
// cfg_i    in   register write: reg_index selects the register, wdata the value
// hit_i    in   one hit: position, weight, used flag, face/panel/index, last
// res_o    out  one result per scan, after the hit marked last
//
// a kept hit is taken and then passes through two multiplies and a sum, the
// bit-serial square root, the residual difference and three more multiplies,
// combine and compare before the unit is ready again
// a skipped hit leaves the unit idle and ready; a last hit adds a step to
// load the result register, which waits while the previous result is unread
// the multiplier and the square root unit are the only arithmetic units
// the result register stands apart from the hit side: hits are taken while a
// result waits, and only the next result load stalls on it
// reset: asynchronous, active low; configuration returns to its reset values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_fit_worst_residual_search_unit #(
  parameter int unsigned NUM_FACES       = 128,
  parameter int unsigned PANELS_PER_FACE = 4,
  parameter int unsigned MAX_HITS        = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfwrs_cfg_if.sink   cfg_i,
  cfwrs_hit_if.sink   hit_i,
  cfwrs_res_if.source res_o
);
  import cfwrs_pkg::*;

  // sequencer codes
  localparam int unsigned StateW = 4;
  localparam logic [StateW-1:0] S_IDLE = 4'd0;
  localparam logic [StateW-1:0] S_MULX = 4'd1;  // dx*dx
  localparam logic [StateW-1:0] S_MULY = 4'd2;  // dy*dy
  localparam logic [StateW-1:0] S_SUM  = 4'd3;  // sum, start root
  localparam logic [StateW-1:0] S_ROOT = 4'd4;  // wait for root
  localparam logic [StateW-1:0] S_DIFF = 4'd5;  // |root - radius|
  localparam logic [StateW-1:0] S_MULR = 4'd6;  // dr*dr
  localparam logic [StateW-1:0] S_WLO  = 4'd7;  // low half of dr^2 times weight
  localparam logic [StateW-1:0] S_WHI  = 4'd8;  // high half of dr^2 times weight
  localparam logic [StateW-1:0] S_CMB  = 4'd9;  // combine and saturate
  localparam logic [StateW-1:0] S_CMP  = 4'd10; // running max update
  localparam logic [StateW-1:0] S_EMIT = 4'd11; // load result register

  localparam logic [CHI2_W-1:0] Chi2Max = '1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] center_x_q, center_y_q;
  logic [RADIUS_W-1:0]       radius_q;
  logic [CHI2_W-1:0]         chi2_start_q;
  logic [FACE_W-1:0]         seed_face_q;
  logic [PANEL_W-1:0]        seed_panel_q;
  logic [WINDEX_W-1:0]       seed_hit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      radius_q     <= '0;
      chi2_start_q <= '0;
      seed_face_q  <= '0;
      seed_panel_q <= '0;
      seed_hit_q   <= '1;   // negative: all hits of the seed panel
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        REG_CENTER_X:   center_x_q   <= cfg_i.wdata[COORD_W-1:0];
        REG_CENTER_Y:   center_y_q   <= cfg_i.wdata[COORD_W-1:0];
        REG_RADIUS:     radius_q     <= cfg_i.wdata[RADIUS_W-1:0];
        REG_CHI2_START: chi2_start_q <= cfg_i.wdata[CHI2_W-1:0];
        REG_SEED_FACE:  seed_face_q  <= cfg_i.wdata[FACE_W-1:0];
        REG_SEED_PANEL: seed_panel_q <= cfg_i.wdata[PANEL_W-1:0];
        REG_SEED_HIT:   seed_hit_q   <= cfg_i.wdata[WINDEX_W-1:0];
        default: ;  // unmapped index, write is dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // hit acceptance and keep decision
  // --------------------------------------------------------------------------
  logic [StateW-1:0] state_q, state_d;
  logic              hit_fire;
  logic              after_seed, in_range, keep;
  logic [COORD_W:0]  dx, dy;
  logic [MAG_W-1:0]  ax, ay;

  assign hit_i.ready = (state_q == S_IDLE);
  assign hit_fire    = hit_i.valid && hit_i.ready;

  always_comb begin
    if (hit_i.face != seed_face_q) begin
      after_seed = hit_i.face > seed_face_q;
    end else if (hit_i.panel != seed_panel_q) begin
      after_seed = hit_i.panel > seed_panel_q;
    end else begin
      after_seed = seed_hit_q[WINDEX_W-1] ||
                   (hit_i.hit_index >= seed_hit_q[INDEX_W-1:0]);
    end
    in_range = (32'(hit_i.face) < NUM_FACES) &&
               (32'(hit_i.panel) < PANELS_PER_FACE) &&
               (32'(hit_i.hit_index) < MAX_HITS);
    keep = hit_i.used && after_seed && in_range;

    // offsets from the center; magnitude stays below 2^20
    dx = {hit_i.hit_x[COORD_W-1], hit_i.hit_x} - {center_x_q[COORD_W-1], center_x_q};
    dy = {hit_i.hit_y[COORD_W-1], hit_i.hit_y} - {center_y_q[COORD_W-1], center_y_q};
    ax = dx[COORD_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
    ay = dy[COORD_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
  end

  // --------------------------------------------------------------------------
  // shared units
  // --------------------------------------------------------------------------
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic              root_start, root_done;
  logic [RAD_W-1:0]  radicand;
  logic [ROOT_W-1:0] root;

  cfwrs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  cfwrs_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (radicand),
    .root_o     (root),
    .done_o     (root_done)
  );

  // --------------------------------------------------------------------------
  // per-hit work registers
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]    ax_q, ay_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [FACE_W-1:0]   face_q;
  logic [PANEL_W-1:0]  panel_q;
  logic [INDEX_W-1:0]  index_q;
  logic                last_q;
  logic [ACC_W-1:0]    acc_q;
  logic [MUL_W-1:0]    adr_q, sq_hi_q;
  logic [CHI2_W-1:0]   chi2_q;

  // running worst of the open scan
  logic                scan_open_q;
  logic                any_found_q;
  logic [CHI2_W-1:0]   best_chi2_q;
  logic [WFACE_W-1:0]  best_face_q;
  logic [WPANEL_W-1:0] best_panel_q;
  logic [WINDEX_W-1:0] best_index_q;

  // result register
  logic                res_valid_q;
  logic                res_found_q;
  logic [CHI2_W-1:0]   res_chi2_q;
  logic [WFACE_W-1:0]  res_face_q;
  logic [WPANEL_W-1:0] res_panel_q;
  logic [WINDEX_W-1:0] res_index_q;
  logic                res_load;

  logic [MUL_W-1:0]    adr_d;
  logic [SUM_W-1:0]    chi2_sum;
  logic [CHI2_W-1:0]   chi2_sat;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MULX: begin
        mul_a = MUL_W'(ax_q);
        mul_b = MUL_W'(ax_q);
      end
      S_MULY: begin
        mul_a = MUL_W'(ay_q);
        mul_b = MUL_W'(ay_q);
      end
      S_MULR: begin
        mul_a = adr_q;
        mul_b = adr_q;
      end
      S_WLO: begin
        mul_a = prod[MUL_W-1:0];   // product register holds dr^2 here
        mul_b = MUL_W'(weight_q);
      end
      S_WHI: begin
        mul_a = sq_hi_q;
        mul_b = MUL_W'(weight_q);
      end
      default: ;
    endcase
  end

  assign root_start = (state_q == S_SUM);
  assign radicand   = RAD_W'(acc_q) + RAD_W'(prod[ACC_W-1:0]);

  always_comb begin
    adr_d = (root >= MUL_W'(radius_q)) ? root - MUL_W'(radius_q)
                                       : MUL_W'(radius_q) - root;
    // product holds sq_hi*w, accumulator holds sq_lo*w
    chi2_sum = {1'b0, prod[PART_W-1:0], {MUL_W{1'b0}}} + SUM_W'(acc_q);
    chi2_sat = (|chi2_sum[SUM_W-1:CHI2_W]) ? Chi2Max : chi2_sum[CHI2_W-1:0];
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign res_load = (state_q == S_EMIT) && (!res_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (hit_fire) begin
          if (keep) begin
            state_d = S_MULX;
          end else if (hit_i.last) begin
            state_d = S_EMIT;
          end
        end
      end
      S_MULX: state_d = S_MULY;
      S_MULY: state_d = S_SUM;
      S_SUM:  state_d = S_ROOT;
      S_ROOT: begin
        if (root_done) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: state_d = S_MULR;
      S_MULR: state_d = S_WLO;
      S_WLO:  state_d = S_WHI;
      S_WHI:  state_d = S_CMB;
      S_CMB:  state_d = S_CMP;
      S_CMP:  state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_open_q <= 1'b0;
      any_found_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // first hit after reset or after a last hit opens the scan
      if (hit_fire && !scan_open_q) begin
        scan_open_q <= 1'b1;
        any_found_q <= 1'b0;
      end
      if ((state_q == S_CMP) && (chi2_q > best_chi2_q)) begin
        any_found_q <= 1'b1;
      end
      if (res_load) begin
        scan_open_q <= 1'b0;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (hit_fire) begin
      ax_q     <= ax;
      ay_q     <= ay;
      weight_q <= hit_i.hit_weight;
      face_q   <= hit_i.face;
      panel_q  <= hit_i.panel;
      index_q  <= hit_i.hit_index;
      last_q   <= hit_i.last;
      if (!scan_open_q) begin
        best_chi2_q  <= chi2_start_q;
        best_face_q  <= '1;
        best_panel_q <= '1;
        best_index_q <= '1;
      end
    end

    unique case (state_q)
      S_MULY: acc_q   <= prod[ACC_W-1:0];          // dx^2
      S_DIFF: adr_q   <= adr_d;
      S_WLO:  sq_hi_q <= prod[PROD_W-1:MUL_W];
      S_WHI:  acc_q   <= ACC_W'(prod[PART_W-1:0]); // sq_lo * w
      S_CMB:  chi2_q  <= chi2_sat;
      S_CMP: begin
        // ties keep the earlier hit
        if (chi2_q > best_chi2_q) begin
          best_chi2_q  <= chi2_q;
          best_face_q  <= {1'b0, face_q};
          best_panel_q <= {1'b0, panel_q};
          best_index_q <= {1'b0, index_q};
        end
      end
      default: ;
    endcase

    if (res_load) begin
      res_found_q <= any_found_q;
      res_chi2_q  <= best_chi2_q;
      res_face_q  <= best_face_q;
      res_panel_q <= best_panel_q;
      res_index_q <= best_index_q;
    end
  end

  // --------------------------------------------------------------------------
  // result channel
  // --------------------------------------------------------------------------
  assign res_o.valid       = res_valid_q;
  assign res_o.found       = res_found_q;
  assign res_o.worst_chi2  = res_chi2_q;
  assign res_o.worst_face  = res_face_q;
  assign res_o.worst_panel = res_panel_q;
  assign res_o.worst_index = res_index_q;

endmodule

// File: rtl/core/cfwrs_checker.sv
// ----------------------------------------------------------------------------
// cfwrs_checker
// port-level checks on the result channel of the worst-residual search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circle_fit_worst_residual_search_unit_defines.svh"

module cfwrs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic                               found_i,
  input logic [cfwrs_pkg::CHI2_W-1:0]       worst_chi2_i,
  input logic [cfwrs_pkg::WFACE_W-1:0]      worst_face_i,
  input logic [cfwrs_pkg::WPANEL_W-1:0]     worst_panel_i,
  input logic [cfwrs_pkg::WINDEX_W-1:0]     worst_index_i
);
  import cfwrs_pkg::*;

  logic res_stall;
  logic res_none;
  logic res_hit;

  assign res_stall = res_valid_i && !res_ready_i;
  assign res_none  = res_valid_i && !found_i;
  assign res_hit   = res_valid_i && found_i;

  `CFWRS_ASSERT_NEXT(a_res_hold, res_stall, res_valid_i, "result dropped while stalled")
  `CFWRS_ASSERT_NEXT(a_res_stable, res_stall, $stable(found_i) && $stable(worst_chi2_i) && $stable(worst_face_i) && $stable(worst_index_i), "result changed while stalled")
  `CFWRS_ASSERT_NOW(a_none_pos, res_none, (&worst_face_i) && (&worst_panel_i) && (&worst_index_i), "no worst hit but position is not minus one")
  `CFWRS_ASSERT_NOW(a_found_pos, res_hit, (worst_chi2_i != '0) && !worst_face_i[WFACE_W-1] && !worst_panel_i[WPANEL_W-1] && !worst_index_i[WINDEX_W-1], "worst hit reported with invalid chi2 or position")

endmodule

bind circle_fit_worst_residual_search_unit cfwrs_checker u_cfwrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .found_i       (res_o.found),
  .worst_chi2_i  (res_o.worst_chi2),
  .worst_face_i  (res_o.worst_face),
  .worst_panel_i (res_o.worst_panel),
  .worst_index_i (res_o.worst_index)
);
